>>> hw/rtl/wsfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wsfs_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_CHUNK_HDR = 3'd1,
    PH_BODY      = 3'd2,
    PH_PAD       = 3'd3,
    PH_SINK      = 3'd4
  } phase_t;

  // Sequencer state
  typedef enum logic [3:0] {
    S_IDLE,
    S_TOT,
    S_MUL,
    S_LIM_START,
    S_LIM,
    S_CNT,
    S_NORM,
    S_ROUND,
    S_EMIT_SAMPLE,
    S_EMIT_STATUS
  } state_t;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER = 3'd1;
  localparam logic [2:0] ST_TRUNCATED  = 3'd2;
  localparam logic [2:0] ST_NO_DATA    = 3'd3;
  localparam logic [2:0] ST_BAD_FORMAT = 3'd4;
  localparam logic [2:0] ST_ORDER      = 3'd5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FPS         = 1'b1;

  // Result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Chunk tags, big-endian as they arrive
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  // Divider geometry
  localparam int DIVIDEND_W = 48;
  localparam int DIVISOR_W  = 18;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

endpackage
`default_nettype wire

>>> hw/rtl/wsfs_div.sv
`timescale 1ns / 1ps
`default_nettype none
module wsfs_div
  import wsfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire div_req_t              req,
  output logic                       busy,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;
  logic                  last_step;

  // Restoring step: one quotient bit per cycle
  assign trial     = {rem, quotient[DIVIDEND_W-1]} - {1'b0, dsr};
  assign fits      = ~trial[DIVISOR_W];
  assign last_step = (cnt == DIV_CNT_W'(DIVIDEND_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && last_step;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dsr  <= req.divisor;
        quotient <= req.dividend;
      end else if (busy) begin
        rem <= fits ? trial[DIVISOR_W-1:0] : {rem[DIVISOR_W-2:0], quotient[DIVIDEND_W-1]};
        quotient <= {quotient[DIVIDEND_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/wav_stream_to_float_samples_top.sv
`timescale 1ns / 1ps
`default_nettype none
// WAV byte stream to IEEE single samples.
// Input channel: one file byte per word (file_byte, end_of_file) under in_valid/in_stall.
// Output channel: result words under out_valid/out_stall; kind 0 is a sample, kind 1 the
// end-of-file status carrying rate_out, channel_count and frames_emitted. last_of_run
// marks the final result word caused by one input byte.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 frame_limit, 1 frames_per_second)
// and cfg_data; write only while the block is idle.
// Stalls: an ordinary byte is taken without a stall. A byte that completes an integer sample
// stalls input while the one-bit-per-cycle normalizing shifter runs (float data skips it).
// The data chunk header stalls input for two passes of the shared
// restoring divider plus the multiplies. An end-of-file byte adds a status step.
// A finished word sits in the output register; the next byte is taken while it waits,
// and the sequencer only waits when a new word must enter a full, stalled register.
// Reset: configuration returns to frame_limit 0, frames_per_second 25, and parsing starts
// at the RIFF header. After each status word the parser returns to that state.
module wav_stream_to_float_samples_top
  import wsfs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           file_byte,
  input  wire logic                 end_of_file,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      kind,
  output logic [31:0]               sample_bits,
  output logic [2:0]                status,
  output logic [31:0]               rate_out,
  output logic [15:0]               channel_count,
  output logic [31:0]               frames_emitted,
  output logic                      last_of_run
);

  // Configuration
  logic [15:0] frame_limit;
  logic [7:0]  frames_per_second;

  // Parser state
  phase_t      parse_phase, parse_phase_next;
  logic [31:0] byte_in_field, byte_in_field_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [15:0] fmt_code, fmt_code_next;
  logic [15:0] channels_seen, channels_seen_next;
  logic [31:0] rate_seen, rate_seen_next;
  logic [15:0] sample_width, sample_width_next;
  logic        fmt_found, fmt_found_next;
  logic        data_found, data_found_next;
  logic [47:0] values_left, values_left_next;
  logic [31:0] sample_assembly, sample_assembly_next;
  logic [2:0]  fault_code, fault_code_next;
  logic [31:0] frames_total;

  // Sequencer and datapath
  state_t      state, state_next;
  logic        eof_hold;
  logic        launch, sample_go;
  logic [31:0] total_q;
  logic [47:0] limit_prod;
  logic [31:0] count;
  logic        conv_sign;
  logic [31:0] conv_mag;
  logic [4:0]  shift_cnt;
  logic [31:0] sample_word;

  logic        in_accept, out_free, load_sample, load_status;
  div_req_t    div_req;
  logic        div_busy, div_done;
  logic [47:0] div_q;

  logic [7:0]  fps_eff;
  logic [31:0] pos, pos_inc;
  logic        is_fmt_body, bps4;
  logic [1:0]  lane;
  logic [31:0] raw_next;
  logic [2:0]  status_calc;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign fps_eff   = (frames_per_second == 8'd0) ? 8'd1 : frames_per_second;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit       <= 16'd0;
      frames_per_second <= 8'd25;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_LIMIT: frame_limit       <= cfg_data;
        CFG_FPS:         frames_per_second <= cfg_data[7:0];
        default:         ;
      endcase
    end
  end

  // Parse one byte
  always_comb begin
    parse_phase_next     = parse_phase;
    byte_in_field_next   = byte_in_field;
    chunk_tag_next       = chunk_tag;
    chunk_length_next    = chunk_length;
    fmt_code_next        = fmt_code;
    channels_seen_next   = channels_seen;
    rate_seen_next       = rate_seen;
    sample_width_next    = sample_width;
    fmt_found_next       = fmt_found;
    data_found_next      = data_found;
    values_left_next     = values_left;
    sample_assembly_next = sample_assembly;
    fault_code_next      = fault_code;
    launch               = 1'b0;
    sample_go            = 1'b0;
    pos                  = byte_in_field;
    pos_inc              = byte_in_field + 32'd1;
    is_fmt_body          = (chunk_tag == TAG_FMT) && (chunk_length >= 32'd16);
    bps4                 = (sample_width != 16'd16);
    lane                 = bps4 ? pos[1:0] : {1'b0, pos[0]};
    unique case (parse_phase)
      PH_HEADER: begin
        if (pos < 32'd4 || pos >= 32'd8) chunk_tag_next = {chunk_tag[23:0], file_byte};
        if ((pos == 32'd3 && chunk_tag_next != TAG_RIFF) ||
            (pos == 32'd11 && chunk_tag_next != TAG_WAVE)) begin
          if (fault_code == ST_OK) fault_code_next = ST_BAD_HEADER;
          parse_phase_next = PH_SINK;
        end else begin
          byte_in_field_next = pos_inc;
          if (pos_inc >= 32'd12) begin
            parse_phase_next   = PH_CHUNK_HDR;
            byte_in_field_next = '0;
            chunk_tag_next     = '0;
            chunk_length_next  = '0;
          end
        end
      end
      PH_CHUNK_HDR: begin
        if (pos < 32'd4) chunk_tag_next = {chunk_tag[23:0], file_byte};
        else chunk_length_next = chunk_length | ({24'd0, file_byte} << {pos[1:0], 3'b000});
        byte_in_field_next = pos_inc;
        if (pos_inc >= 32'd8) begin
          byte_in_field_next = '0;
          // Chunk header complete: decide on the tag
          if (chunk_tag_next == TAG_FMT && chunk_length_next >= 32'd16 && data_found) begin
            if (fault_code == ST_OK) fault_code_next = ST_ORDER;
            parse_phase_next = PH_SINK;
          end else if (chunk_tag_next == TAG_DATA && (!fmt_found || data_found)) begin
            if (fault_code == ST_OK) fault_code_next = ST_ORDER;
            parse_phase_next = PH_SINK;
          end else if (chunk_tag_next == TAG_DATA &&
                       !(channels_seen != 16'd0 && rate_seen != 32'd0 &&
                         ((fmt_code == FMT_PCM &&
                           (sample_width == 16'd16 || sample_width == 16'd32)) ||
                          (fmt_code == FMT_FLOAT && sample_width == 16'd32)))) begin
            if (fault_code == ST_OK) fault_code_next = ST_BAD_FORMAT;
            parse_phase_next = PH_SINK;
          end else begin
            if (chunk_tag_next == TAG_FMT && chunk_length_next >= 32'd16)
              fmt_found_next = 1'b1;
            if (chunk_tag_next == TAG_DATA) begin
              data_found_next = 1'b1;
              launch          = 1'b1;
            end
            if (chunk_length_next == 32'd0) begin
              parse_phase_next  = PH_CHUNK_HDR;
              chunk_tag_next    = '0;
              chunk_length_next = '0;
            end else begin
              parse_phase_next = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        if (is_fmt_body) begin
          priority if (pos == 32'd0) fmt_code_next = {8'd0, file_byte};
          else if (pos == 32'd1) fmt_code_next = {file_byte, fmt_code[7:0]};
          else if (pos == 32'd2) channels_seen_next = {8'd0, file_byte};
          else if (pos == 32'd3) channels_seen_next = {file_byte, channels_seen[7:0]};
          else if (pos == 32'd4) rate_seen_next = {24'd0, file_byte};
          else if (pos >= 32'd5 && pos <= 32'd7)
            rate_seen_next = rate_seen | ({24'd0, file_byte} << {pos[1:0], 3'b000});
          else if (pos == 32'd14) sample_width_next = {8'd0, file_byte};
          else if (pos == 32'd15) sample_width_next = {file_byte, sample_width[7:0]};
          else ;
        end else if (chunk_tag == TAG_DATA && data_found) begin
          if (lane == 2'd0) sample_assembly_next = {24'd0, file_byte};
          else sample_assembly_next =
                 sample_assembly | ({24'd0, file_byte} << {lane, 3'b000});
          if (lane == (bps4 ? 2'd3 : 2'd1) && values_left != 48'd0) begin
            sample_go        = 1'b1;
            values_left_next = values_left - 48'd1;
          end
        end
        byte_in_field_next = pos_inc;
        if (pos_inc == chunk_length) begin
          if (chunk_length[0]) begin
            parse_phase_next   = PH_PAD;
            byte_in_field_next = '0;
          end else begin
            parse_phase_next   = PH_CHUNK_HDR;
            byte_in_field_next = '0;
            chunk_tag_next     = '0;
            chunk_length_next  = '0;
          end
        end
      end
      PH_PAD: begin
        parse_phase_next   = PH_CHUNK_HDR;
        byte_in_field_next = '0;
        chunk_tag_next     = '0;
        chunk_length_next  = '0;
      end
      default: ;
    endcase
    raw_next = bps4 ? sample_assembly_next : {sample_assembly_next[15:0], 16'd0};
  end

  // End-of-file status from the state left by the last byte
  always_comb begin
    status_calc = fault_code;
    if (fault_code == ST_OK) begin
      priority if (parse_phase == PH_HEADER) status_calc = ST_BAD_HEADER;
      else if (parse_phase == PH_BODY) status_calc = ST_TRUNCATED;
      else if (!data_found) status_calc = ST_NO_DATA;
      else ;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          priority if (launch) state_next = S_TOT;
          else if (sample_go) state_next = (fmt_code == FMT_FLOAT) ? S_ROUND : S_NORM;
          else if (end_of_file) state_next = S_EMIT_STATUS;
          else ;
        end
      end
      S_TOT:       if (div_done) state_next = S_MUL;
      S_MUL:       state_next = S_LIM_START;
      S_LIM_START: state_next = S_LIM;
      S_LIM:       if (div_done) state_next = S_CNT;
      S_CNT:       state_next = eof_hold ? S_EMIT_STATUS : S_IDLE;
      S_NORM:      if (conv_mag[31] || conv_mag == 32'd0) state_next = S_ROUND;
      S_ROUND:     state_next = S_EMIT_SAMPLE;
      S_EMIT_SAMPLE: if (out_free) state_next = eof_hold ? S_EMIT_STATUS : S_IDLE;
      S_EMIT_STATUS: if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall         = (state != S_IDLE);
    load_sample      = (state == S_EMIT_SAMPLE) && out_free;
    load_status      = (state == S_EMIT_STATUS) && out_free;
    div_req.start    = 1'b0;
    div_req.dividend = {16'd0, chunk_length_next};
    div_req.divisor  = bps4 ? {channels_seen, 2'b00} : {1'b0, channels_seen, 1'b0};
    if (state == S_IDLE) begin
      div_req.start = in_accept && launch;
    end else begin
      div_req.start    = (state == S_LIM_START);
      div_req.dividend = limit_prod;
      div_req.divisor  = {10'd0, fps_eff};
    end
  end

  wsfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Parser registers: step on an accepted word, take the frame count in S_CNT, clear after the status word
  always_ff @(posedge clk) begin
    if (rst || load_status) begin
      parse_phase     <= PH_HEADER;
      byte_in_field   <= '0;
      chunk_tag       <= '0;
      chunk_length    <= '0;
      fmt_code        <= '0;
      channels_seen   <= '0;
      rate_seen       <= '0;
      sample_width    <= '0;
      fmt_found       <= 1'b0;
      data_found      <= 1'b0;
      values_left     <= '0;
      sample_assembly <= '0;
      fault_code      <= ST_OK;
      frames_total    <= '0;
    end else if (in_accept) begin
      parse_phase     <= parse_phase_next;
      byte_in_field   <= byte_in_field_next;
      chunk_tag       <= chunk_tag_next;
      chunk_length    <= chunk_length_next;
      fmt_code        <= fmt_code_next;
      channels_seen   <= channels_seen_next;
      rate_seen       <= rate_seen_next;
      sample_width    <= sample_width_next;
      fmt_found       <= fmt_found_next;
      data_found      <= data_found_next;
      values_left     <= values_left_next;
      sample_assembly <= sample_assembly_next;
      fault_code      <= fault_code_next;
    end else if (state == S_CNT) begin
      frames_total <= count;
      values_left  <= 48'(count * channels_seen);
    end
  end

  // Round to nearest even into single precision
  function automatic logic [31:0] rounded_word(input logic sgn, input logic [31:0] n,
                                               input logic [4:0] s);
    logic        up;
    logic [24:0] mant;
    logic [7:0]  expo;
    up   = n[7] && ((|n[6:0]) || n[8]);
    mant = {1'b0, n[31:8]} + {24'd0, up};
    expo = 8'd127 - {3'd0, s} + {7'd0, mant[24]};
    rounded_word = {sgn, expo, mant[24] ? mant[23:1] : mant[22:0]};
  endfunction

  // Arithmetic datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      eof_hold <= 1'b0;
    end else if (in_accept) begin
      eof_hold <= end_of_file;
    end
    if (in_accept) begin
      conv_sign   <= raw_next[31];
      conv_mag    <= raw_next[31] ? (32'd0 - raw_next) : raw_next;
      shift_cnt   <= '0;
      sample_word <= raw_next;
    end
    unique case (state)
      S_TOT: if (div_done) total_q <= div_q[31:0];
      S_MUL: limit_prod <= 48'(frame_limit * rate_seen);
      S_LIM: if (div_done) count <= (48'(total_q) < div_q) ? total_q : div_q[31:0];
      S_NORM: begin
        // Shift toward the leading one
        if (!conv_mag[31] && conv_mag != 32'd0) begin
          conv_mag  <= {conv_mag[30:0], 1'b0};
          shift_cnt <= shift_cnt + 5'd1;
        end
      end
      S_ROUND: begin
        if (fmt_code != FMT_FLOAT) begin
          if (conv_mag == 32'd0) sample_word <= 32'd0;
          else sample_word <= rounded_word(conv_sign, conv_mag, shift_cnt);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_sample || load_status) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load_sample) begin
      kind           <= KIND_SAMPLE;
      sample_bits    <= sample_word;
      status         <= ST_OK;
      rate_out       <= '0;
      channel_count  <= '0;
      frames_emitted <= '0;
      last_of_run    <= !eof_hold;
    end else if (load_status) begin
      kind           <= KIND_STATUS;
      sample_bits    <= '0;
      status         <= status_calc;
      rate_out       <= rate_seen;
      channel_count  <= channels_seen;
      frames_emitted <= (status_calc == ST_OK) ? frames_total : 32'd0;
      last_of_run    <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> last_of_run)
    else $error("status word without last_of_run");

  a_sample_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> status == ST_OK && rate_out == 32'd0 && frames_emitted == 32'd0)
    else $error("sample word carries status fields");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == S_TOT || state == S_LIM)
    else $error("divider busy outside a divide step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_bits) && $stable(kind))
    else $error("stalled result word overwritten");
`endif

endmodule
`default_nettype wire
